/* rtl/deq_pkg.sv */
// Shared types and constants for the double-ended queue core.
// No dependencies; compiled first.
package deq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned OCC_W  = 11;

  // Operation codes carried in the kind field; other codes act as look only.
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOOK       = 3'd4;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic                     underflow;
    logic                     overflow;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_empty;
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] back_word;
  } deq_res_t;

endpackage

/* rtl/deq_if.sv */
// Valid/ready channel interfaces for operation items and result items.
// Depends on deq_pkg.
interface deq_in_if;
  import deq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface deq_out_if;
  import deq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] popped_value;
  logic                     underflow;
  logic                     overflow;
  logic [OCC_W-1:0]         occupancy;
  logic                     is_empty;
  logic signed [WORD_W-1:0] front_word;
  logic signed [WORD_W-1:0] back_word;

  modport source (output valid, output popped_value, output underflow, output overflow,
                  output occupancy, output is_empty, output front_word, output back_word,
                  input ready);
  modport sink   (input valid, input popped_value, input underflow, input overflow,
                  input occupancy, input is_empty, input front_word, input back_word,
                  output ready);
endinterface

/* rtl/double_ended_queue_core.sv */
// Double-ended queue of signed 32-bit words held in a DEPTH-entry ring buffer.
// Usage:
//   in_ch  : operation items (kind, push_value). kind 0 push front, 1 push
//            back, 2 pop front, 3 pop back, 4..7 look only.
//   out_ch : one result item per operation: popped word (or -1 with underflow),
//            overflow for a dropped push, occupancy, empty flag, and the
//            front and back words (-1 when empty).
// Timing:
//   An item is taken when the core is idle. Pushes, looks and pops that leave
//   one word or none go from idle straight to the hold state; pops that
//   leave two or more pass through the read state first, since the new end
//   word comes back from the word memory's registered read port only after
//   the pop moves the index.
//   The end words are cached in registers, so pushes never read the memory.
// Reset: rst_n (synchronous, active low) empties the queue; memory contents
//   are not cleared and are never read before being written.
// Stall: the result sits in an output register; the core finishes the next
//   item and then holds its result until the output register frees up.
// Depends on deq_pkg, deq_if, deq_ctrl, deq_out.
module double_ended_queue_core
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);

  deq_res_t res;
  logic     res_vld;
  logic     res_take;

  // index/count bookkeeping plus the word memory
  deq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .res_o      (res),
    .res_vld_o  (res_vld),
    .res_take_i (res_take)
  );

  // result item register toward the sink
  deq_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_i      (res),
    .res_vld_i  (res_vld),
    .res_take_o (res_take),
    .out_ch     (out_ch)
  );

endmodule

/* rtl/deq_ctrl.sv */
// Queue control: ring indices, count, cached end words and the word memory.
// Depends on deq_pkg and deq_in_if.
module deq_ctrl
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  deq_in_if.sink    in_ch,
  output deq_res_t  res_o,
  output logic      res_vld_o,
  input  logic      res_take_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
  endfunction

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rdata_r;

  logic [1:0]               state_r, state_nxt;
  logic [AW-1:0]            fi_r, fi_nxt;
  logic [AW-1:0]            bi_r, bi_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic signed [WORD_W-1:0] front_w_r, front_w_nxt;
  logic signed [WORD_W-1:0] back_w_r, back_w_nxt;
  logic signed [WORD_W-1:0] popped_r, popped_nxt;
  logic                     under_r, under_nxt;
  logic                     over_r, over_nxt;
  logic                     rd_front_r, rd_front_nxt;

  logic                     we, re;
  logic [AW-1:0]            waddr, raddr;
  logic                     full, empty;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    fi_nxt       = fi_r;
    bi_nxt       = bi_r;
    cnt_nxt      = cnt_r;
    front_w_nxt  = front_w_r;
    back_w_nxt   = back_w_r;
    popped_nxt   = popped_r;
    under_nxt    = under_r;
    over_nxt     = over_r;
    rd_front_nxt = rd_front_r;
    we           = 1'b0;
    re           = 1'b0;
    waddr        = bi_r;
    raddr        = fi_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt  = S_HOLD;
          popped_nxt = '0;
          under_nxt  = 1'b0;
          over_nxt   = 1'b0;
          unique case (in_ch.kind)
            KIND_PUSH_FRONT: begin
              if (full) begin
                over_nxt = 1'b1;
              end else begin
                fi_nxt      = ring_prev(fi_r);
                we          = 1'b1;
                waddr       = fi_nxt;
                cnt_nxt     = cnt_r + CW'(1);
                front_w_nxt = in_ch.push_value;
                if (empty) back_w_nxt = in_ch.push_value;
              end
            end
            KIND_PUSH_BACK: begin
              if (full) begin
                over_nxt = 1'b1;
              end else begin
                we         = 1'b1;
                waddr      = bi_r;
                bi_nxt     = ring_next(bi_r);
                cnt_nxt    = cnt_r + CW'(1);
                back_w_nxt = in_ch.push_value;
                if (empty) front_w_nxt = in_ch.push_value;
              end
            end
            KIND_POP_FRONT: begin
              if (empty) begin
                popped_nxt = EMPTY_WORD;
                under_nxt  = 1'b1;
              end else begin
                popped_nxt = front_w_r;
                fi_nxt     = ring_next(fi_r);
                cnt_nxt    = cnt_r - CW'(1);
                // two left: the survivor is the cached back word
                if (cnt_r == CW'(2)) begin
                  front_w_nxt = back_w_r;
                end else if (cnt_r > CW'(2)) begin
                  re           = 1'b1;
                  raddr        = fi_nxt;
                  rd_front_nxt = 1'b1;
                  state_nxt    = S_READ;
                end
              end
            end
            KIND_POP_BACK: begin
              if (empty) begin
                popped_nxt = EMPTY_WORD;
                under_nxt  = 1'b1;
              end else begin
                popped_nxt = back_w_r;
                bi_nxt     = ring_prev(bi_r);
                cnt_nxt    = cnt_r - CW'(1);
                if (cnt_r == CW'(2)) begin
                  back_w_nxt = front_w_r;
                end else if (cnt_r > CW'(2)) begin
                  re           = 1'b1;
                  raddr        = ring_prev(bi_nxt);
                  rd_front_nxt = 1'b0;
                  state_nxt    = S_READ;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (rd_front_r) front_w_nxt = rdata_r;
        else            back_w_nxt  = rdata_r;
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (res_take_i) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // word memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= in_ch.push_value;
    if (re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fi_r    <= '0;
      bi_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fi_r    <= fi_nxt;
      bi_r    <= bi_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_w_r  <= front_w_nxt;
    back_w_r   <= back_w_nxt;
    popped_r   <= popped_nxt;
    under_r    <= under_nxt;
    over_r     <= over_nxt;
    rd_front_r <= rd_front_nxt;
  end

  assign res_vld_o          = (state_r == S_HOLD);
  assign res_o.popped_value = popped_r;
  assign res_o.underflow    = under_r;
  assign res_o.overflow     = over_r;
  assign res_o.occupancy    = OCC_W'(cnt_r);
  assign res_o.is_empty     = empty;
  assign res_o.front_word   = empty ? EMPTY_WORD : front_w_r;
  assign res_o.back_word    = empty ? EMPTY_WORD : back_w_r;

endmodule

/* rtl/deq_out.sv */
// Output register for result items; frees the core while the sink stalls.
// Depends on deq_pkg and deq_out_if.
module deq_out
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  deq_res_t  res_i,
  input  logic      res_vld_i,
  output logic      res_take_o,
  deq_out_if.source out_ch
);

  logic     vld_r;
  deq_res_t res_r;

  assign res_take_o = res_vld_i && (!vld_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_take_o) begin
      vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take_o) res_r <= res_i;
  end

  assign out_ch.valid        = vld_r;
  assign out_ch.popped_value = res_r.popped_value;
  assign out_ch.underflow    = res_r.underflow;
  assign out_ch.overflow     = res_r.overflow;
  assign out_ch.occupancy    = res_r.occupancy;
  assign out_ch.is_empty     = res_r.is_empty;
  assign out_ch.front_word   = res_r.front_word;
  assign out_ch.back_word    = res_r.back_word;

endmodule

/* tb/deq_checker.sv */
// Scoreboard for double_ended_queue_core: mirrors the ring buffer, predicts
// one result per accepted operation and compares results in order.
// Depends on deq_pkg and the deq_in_if / deq_out_if interfaces.
module deq_checker
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  deq_in_if           in_mon,
  deq_out_if          out_mon,
  output int unsigned pending,
  output int unsigned mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the ring buffer
  logic signed [WORD_W-1:0] mirror_words [DEPTH];
  int unsigned              mirror_front;
  int unsigned              mirror_back;   // one past the back word
  int unsigned              mirror_count;

  deq_res_t    expected_results [$];
  int unsigned result_index;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) begin
      $display("%0t ns: mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %h want %h",
                                result_index, name, got, want));
    end
  endtask

  function automatic int unsigned slot_before(input int unsigned idx);
    return (idx == 0) ? DEPTH - 1 : idx - 1;
  endfunction

  // Applies one operation to the shadow buffer and returns the result it gives
  function automatic deq_res_t predict_result(input logic [KIND_W-1:0] op,
                                              input logic signed [WORD_W-1:0] word);
    deq_res_t res;
    res = '0;
    case (op)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (mirror_count == DEPTH) begin
          res.overflow = 1'b1;
        end else if (op == KIND_PUSH_FRONT) begin
          mirror_front = slot_before(mirror_front);
          mirror_words[mirror_front] = word;
          mirror_count++;
        end else begin
          mirror_words[mirror_back] = word;
          mirror_back = (mirror_back == DEPTH - 1) ? 0 : mirror_back + 1;
          mirror_count++;
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (mirror_count == 0) begin
          res.popped_value = EMPTY_WORD;
          res.underflow = 1'b1;
        end else if (op == KIND_POP_FRONT) begin
          res.popped_value = mirror_words[mirror_front];
          mirror_front = (mirror_front == DEPTH - 1) ? 0 : mirror_front + 1;
          mirror_count--;
        end else begin
          mirror_back = slot_before(mirror_back);
          res.popped_value = mirror_words[mirror_back];
          mirror_count--;
        end
      end
      default: ;  // look only, including the unused codes
    endcase
    res.occupancy = mirror_count[OCC_W-1:0];
    res.is_empty = (mirror_count == 0);
    if (mirror_count == 0) begin
      res.front_word = EMPTY_WORD;
      res.back_word = EMPTY_WORD;
    end else begin
      res.front_word = mirror_words[mirror_front];
      res.back_word = mirror_words[slot_before(mirror_back)];
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    deq_res_t want;
    if (!rst_n) begin
      mirror_front = 0;
      mirror_back = 0;
      mirror_count = 0;
      expected_results.delete();
    end else begin
      // a result at this edge can only belong to an earlier operation
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none pending", result_index));
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          check_field("popped_value", out_mon.popped_value, want.popped_value);
          check_field("underflow", WORD_W'(out_mon.underflow), WORD_W'(want.underflow));
          check_field("overflow", WORD_W'(out_mon.overflow), WORD_W'(want.overflow));
          check_field("occupancy", WORD_W'(out_mon.occupancy), WORD_W'(want.occupancy));
          check_field("is_empty", WORD_W'(out_mon.is_empty), WORD_W'(want.is_empty));
          check_field("front_word", out_mon.front_word, want.front_word);
          check_field("back_word", out_mon.back_word, want.back_word);
        end
        result_index++;
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_results.insert(expected_results.size(),
                                predict_result(in_mon.kind, in_mon.push_value));
      end
    end
    pending <= expected_results.size();
  end

endmodule

/* tb/tb.sv */
// Testbench top for double_ended_queue_core: drives operation items, stalls
// the result side, and prints the verdict from the checker's counts.
// Depends on deq_pkg, deq_if, the core RTL and deq_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import deq_pkg::*;

  localparam int unsigned DEPTH = 1024;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned pending;
  int unsigned mismatch_count;

  // Idle odds: 0 means no idling, N means a burst starts with chance 1/N
  int unsigned gap_odds;
  int unsigned stall_odds;

  deq_in_if  in_ch ();
  deq_out_if out_ch ();

  double_ended_queue_core #(
    .DEPTH (DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deq_checker #(
    .DEPTH (DEPTH)
  ) scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .pending        (pending),
    .mismatch_count (mismatch_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop. Worst case is roughly 1260 items, each costing sender gap + core
  // + receiver stall, about 0.45 ms in all; this is over 15x that.
  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

  // Mostly random words, with the sign/extreme patterns mixed in often.
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return EMPTY_WORD;   // a stored -1 looks like the empty marker
      default: return $urandom();
    endcase
  endfunction

  // One item on the operation channel. Inputs move at the falling edge;
  // acceptance is seen at the rising edge. valid is left high on return so
  // back-to-back items need no drop; whoever idles next lowers it.
  task automatic send_op(input logic [KIND_W-1:0] op,
                         input logic signed [WORD_W-1:0] word);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= op;
    in_ch.push_value <= word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random operation: push_pct percent pushes, pops up to 95 percent, and the
  // last 5 percent looks spread over the look code and the three unused codes.
  task automatic send_random(input int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      send_op(($urandom_range(0, 1) != 0) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, pick_word());
    end else if (roll < 95) begin
      send_op(($urandom_range(0, 1) != 0) ? KIND_POP_BACK : KIND_POP_FRONT, pick_word());
    end else begin
      send_op(KIND_LOOK + 3'($urandom_range(0, 3)), pick_word());
    end
  endtask

  // Sender holds off until every predicted result has been consumed.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Result side: ready drops in random bursts while stall_odds is nonzero.
  initial begin : sink_side
    int unsigned hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        hold = $urandom_range(1, 13);
      end
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned seg;
    int unsigned n;
    int unsigned push_pct;

    gap_odds = 0;
    stall_odds = 0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOOK;
    in_ch.push_value = '0;
    rst_n = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed ----
    gap_odds = 4;
    stall_odds = 4;
    // empty queue: both pop ends underflow, look and the unused codes idle
    send_op(KIND_POP_FRONT, 32'sh1234_5678);
    send_op(KIND_POP_BACK, 32'sh1234_5678);
    send_op(KIND_LOOK, 32'sh7fff_ffff);
    send_op(KIND_LOOK + 3'd1, 32'sh8000_0000);
    send_op(KIND_LOOK + 3'd2, 32'sh5555_5555);
    send_op(KIND_LOOK + 3'd3, 32'shaaaa_aaaa);
    // extreme words at both ends; push front from slot 0 wraps at once
    send_op(KIND_PUSH_BACK, 32'sh7fff_ffff);
    send_op(KIND_PUSH_FRONT, 32'sh8000_0000);
    send_op(KIND_PUSH_BACK, '0);
    send_op(KIND_PUSH_FRONT, EMPTY_WORD);
    send_op(KIND_PUSH_BACK, 32'sh5555_5555);
    send_op(KIND_PUSH_FRONT, 32'shaaaa_aaaa);
    send_op(KIND_LOOK, '0);
    // pop down through the two-or-more / one-or-none boundary
    send_op(KIND_POP_BACK, '0);
    send_op(KIND_POP_FRONT, '0);
    send_op(KIND_POP_FRONT, '0);
    send_op(KIND_POP_BACK, '0);
    send_op(KIND_POP_BACK, '0);
    send_op(KIND_POP_FRONT, '0);
    send_op(KIND_POP_BACK, '0);
    // single word: front and back are the same entry
    send_op(KIND_PUSH_FRONT, 32'sd1);
    send_op(KIND_POP_BACK, '0);
    send_op(KIND_PUSH_BACK, 32'sd2);
    send_op(KIND_POP_FRONT, '0);
    wait_drained();

    // ---- random, low occupancy: segments with varying push bias ----
    for (seg = 0; seg < 20; seg++) begin
      case ($urandom_range(0, 4))
        0: push_pct = 10;
        1: push_pct = 35;
        2: push_pct = 50;
        3: push_pct = 65;
        default: push_pct = 90;
      endcase
      case ($urandom_range(0, 3))
        0: gap_odds = 0;
        1: gap_odds = 3;
        2: gap_odds = 6;
        default: gap_odds = 12;
      endcase
      case ($urandom_range(0, 3))
        0: stall_odds = 0;
        1: stall_odds = 3;
        2: stall_odds = 6;
        default: stall_odds = 12;
      endcase
      for (n = 0; n < 5; n++) send_random(push_pct);
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    // ---- fill past capacity: the last pushes find the queue full ----
    gap_odds = 8;
    stall_odds = 8;
    for (n = 0; n < DEPTH + 8; n++) begin
      send_op(($urandom_range(0, 1) != 0) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, pick_word());
    end
    wait_drained();
    // churn around full
    for (n = 0; n < 40; n++) send_random(50);

    // ---- tail: full rate on both sides ----
    gap_odds = 0;
    stall_odds = 0;
    for (n = 0; n < 60; n++) send_random(55);

    in_ch.valid <= 1'b0;
    for (n = 0; n < 5000 && pending != 0; n++) @(negedge clk);
    // settle time for any stray results before the verdict
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
